@@ src/htab_pkg.sv @@
// Shared types and codes for the handle table engine.
package htab_pkg;

    localparam logic [1:0] OP_ALLOC = 2'd0;
    localparam logic [1:0] OP_CLOSE = 2'd1;
    localparam logic [1:0] OP_GET   = 2'd2;
    localparam logic [1:0] OP_SET   = 2'd3;

    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_INVALID = 2'd1;
    localparam logic [1:0] ST_DENIED  = 2'd2;
    localparam logic [1:0] ST_FULL    = 2'd3;

    localparam int RIGHTS_BITS = 25;
    localparam int ACCESS_BITS = 27;
    localparam int FD_BITS     = 17;
    localparam int HOUT_BITS   = 11;
    localparam int HANDLE_BITS = 32;
    localparam logic [FD_BITS-1:0] NO_FD = '1;

    typedef enum logic [5:0] {
        S_IDLE = 6'b000001,
        S_SCAN = 6'b000010,
        S_READ = 6'b000100,
        S_EXEC = 6'b001000,
        S_TRIM = 6'b010000,
        S_DONE = 6'b100000
    } htab_state_t;

    typedef struct packed {
        logic load_item;
        logic scan_step;
        logic alloc_commit;
        logic set_invalid;
        logic exec;
        logic trim_step;
        logic load_out;
    } htab_cmd_t;

    typedef struct packed {
        logic is_alloc;
        logic scan_stop;
        logic decode_ok;
        logic need_trim;
        logic trim_stop;
        logic out_free;
    } htab_sts_t;

endpackage

@@ src/htab_ctrl.sv @@
// Controller state machine of the handle table engine.
module htab_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  htab_pkg::htab_sts_t sts,
    output htab_pkg::htab_cmd_t cmd
);

    htab_pkg::htab_state_t state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= htab_pkg::S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    assign in_ready = (state_reg == htab_pkg::S_IDLE);

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            htab_pkg::S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load_item = 1'b1;
                    state_next    = sts.is_alloc ? htab_pkg::S_SCAN : htab_pkg::S_READ;
                end
            end
            htab_pkg::S_SCAN:
            begin
                if (sts.scan_stop)
                begin
                    cmd.alloc_commit = 1'b1;
                    state_next       = htab_pkg::S_DONE;
                end
                else
                begin
                    cmd.scan_step = 1'b1;
                end
            end
            htab_pkg::S_READ:
            begin
                if (sts.decode_ok)
                begin
                    state_next = htab_pkg::S_EXEC;
                end
                else
                begin
                    cmd.set_invalid = 1'b1;
                    state_next      = htab_pkg::S_DONE;
                end
            end
            htab_pkg::S_EXEC:
            begin
                cmd.exec   = 1'b1;
                state_next = sts.need_trim ? htab_pkg::S_TRIM : htab_pkg::S_DONE;
            end
            htab_pkg::S_TRIM:
            begin
                if (sts.trim_stop)
                begin
                    state_next = htab_pkg::S_DONE;
                end
                else
                begin
                    cmd.trim_step = 1'b1;
                end
            end
            htab_pkg::S_DONE:
            begin
                if (sts.out_free)
                begin
                    cmd.load_out = 1'b1;
                    state_next   = htab_pkg::S_IDLE;
                end
            end
            default:
            begin
                state_next = htab_pkg::S_IDLE;
            end
        endcase
    end

endmodule

@@ src/htab_dp.sv @@
// Datapath of the handle table engine: used bits, entry memory, indices, result.
module htab_dp #(
    parameter int TABLE_ENTRIES = 256,
    parameter int OBJECT_BITS   = 16
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  htab_pkg::htab_cmd_t                  cmd,
    output htab_pkg::htab_sts_t                  sts,
    input  logic [1:0]                           in_operation,
    input  logic [htab_pkg::HANDLE_BITS-1:0]     in_handle,
    input  logic [OBJECT_BITS-1:0]               in_object_id,
    input  logic [htab_pkg::RIGHTS_BITS-1:0]     in_access_rights,
    input  logic                                 in_inherit_flag,
    input  logic [1:0]                           in_flag_mask,
    input  logic [1:0]                           in_flag_values,
    input  logic [htab_pkg::FD_BITS-1:0]         in_fd_value,
    input  logic                                 out_ready,
    output logic                                 out_valid,
    output logic [1:0]                           out_status,
    output logic [htab_pkg::HOUT_BITS-1:0]       out_handle,
    output logic [OBJECT_BITS-1:0]               out_object,
    output logic [1:0]                           out_prev_flags,
    output logic [htab_pkg::FD_BITS-1:0]         out_fd
);

    localparam int IW = $clog2(TABLE_ENTRIES);
    localparam int EW = OBJECT_BITS + htab_pkg::ACCESS_BITS + htab_pkg::FD_BITS;
    localparam logic [IW:0] DEPTH = (IW+1)'(TABLE_ENTRIES);

    logic [1:0]                       op_reg;
    logic [htab_pkg::HANDLE_BITS-1:0] handle_reg;
    logic [OBJECT_BITS-1:0]           obj_reg;
    logic [htab_pkg::RIGHTS_BITS-1:0] acc_reg;
    logic                             inh_reg;
    logic [1:0]                       mask_reg;
    logic [1:0]                       val_reg;
    logic [htab_pkg::FD_BITS-1:0]     fdv_reg;

    logic [TABLE_ENTRIES-1:0] used_reg;
    logic [IW:0]              count_reg;
    logic [IW:0]              hint_reg;
    logic [IW:0]              idx_reg;

    logic [EW-1:0] mem [TABLE_ENTRIES];
    logic [EW-1:0] rd_reg;
    logic          we;
    logic [IW-1:0] wa;
    logic [EW-1:0] wd;

    logic [1:0]                       res_status_reg;
    logic [htab_pkg::HOUT_BITS-1:0]   res_handle_reg;
    logic [OBJECT_BITS-1:0]           res_object_reg;
    logic [1:0]                       res_flags_reg;
    logic [htab_pkg::FD_BITS-1:0]     res_fd_reg;
    logic [1:0]                       res_status_next;
    logic [htab_pkg::HOUT_BITS-1:0]   res_handle_next;
    logic [OBJECT_BITS-1:0]           res_object_next;
    logic [1:0]                       res_flags_next;
    logic [htab_pkg::FD_BITS-1:0]     res_fd_next;
    logic                             out_valid_reg;

    logic [29:0]   q;
    logic [29:0]   ix_full;
    logic [IW-1:0] ix;
    logic          found;
    logic          full;
    logic [IW:0]   cnt_m1;
    logic [31:0]   hout_wide;

    logic [OBJECT_BITS-1:0]           rd_obj;
    logic [htab_pkg::ACCESS_BITS-1:0] rd_acc;
    logic [htab_pkg::FD_BITS-1:0]     rd_fd;
    logic                             protect;
    logic [1:0]                       new_flags;
    logic [htab_pkg::FD_BITS-1:0]     new_fd;
    logic                             rights_ok;

    assign q       = handle_reg[31:2];
    assign ix_full = q - 30'd1;
    assign ix      = ix_full[IW-1:0];
    assign found   = (idx_reg < count_reg) && !used_reg[idx_reg[IW-1:0]];
    assign full    = !found && (idx_reg >= DEPTH);
    assign cnt_m1  = count_reg - (IW+1)'(1);
    assign hout_wide = (32'(idx_reg) + 32'd1) << 2;

    assign rd_obj    = rd_reg[OBJECT_BITS-1:0];
    assign rd_acc    = rd_reg[OBJECT_BITS +: htab_pkg::ACCESS_BITS];
    assign rd_fd     = rd_reg[OBJECT_BITS + htab_pkg::ACCESS_BITS +: htab_pkg::FD_BITS];
    assign protect   = rd_acc[26];
    assign new_flags = (rd_acc[26:25] & ~mask_reg) | (val_reg & mask_reg);
    assign new_fd    = (rd_fd == htab_pkg::NO_FD) ? fdv_reg : rd_fd;
    assign rights_ok = ((rd_acc[24:0] & acc_reg) == acc_reg);

    always_comb
    begin
        sts.is_alloc  = (in_operation == htab_pkg::OP_ALLOC);
        sts.scan_stop = !(idx_reg < count_reg) || found;
        sts.decode_ok = (q != 30'd0) && (ix_full < 30'(count_reg)) && used_reg[ix];
        sts.need_trim = (op_reg == htab_pkg::OP_CLOSE) && !protect
                        && (({1'b0, ix} + (IW+1)'(1)) == count_reg);
        sts.trim_stop = (count_reg == '0) || used_reg[cnt_m1[IW-1:0]];
        sts.out_free  = !out_valid_reg || out_ready;
    end

    // Memory write port: allocate writes a fresh entry, close and set_info rewrite one.
    always_comb
    begin
        we = 1'b0;
        wa = ix;
        wd = rd_reg;
        if (cmd.alloc_commit && !full)
        begin
            we = 1'b1;
            wa = idx_reg[IW-1:0];
            wd = {htab_pkg::NO_FD, 1'b0, inh_reg, acc_reg, obj_reg};
        end
        else if (cmd.exec && op_reg == htab_pkg::OP_CLOSE && !protect)
        begin
            we = 1'b1;
            wd = {htab_pkg::NO_FD, rd_acc, rd_obj};
        end
        else if (cmd.exec && op_reg == htab_pkg::OP_SET)
        begin
            we = 1'b1;
            wd = {new_fd, new_flags, rd_acc[24:0], rd_obj};
        end
    end

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[wa] <= wd;
        end
        rd_reg <= mem[ix];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            used_reg      <= '0;
            count_reg     <= '0;
            hint_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.alloc_commit && !full)
            begin
                used_reg[idx_reg[IW-1:0]] <= 1'b1;
                hint_reg                  <= idx_reg + (IW+1)'(1);
                if (!found)
                begin
                    count_reg <= idx_reg + (IW+1)'(1);
                end
            end
            if (cmd.exec && op_reg == htab_pkg::OP_CLOSE && !protect)
            begin
                used_reg[ix] <= 1'b0;
                if ({1'b0, ix} < hint_reg)
                begin
                    hint_reg <= {1'b0, ix};
                end
            end
            if (cmd.trim_step)
            begin
                count_reg <= cnt_m1;
            end
            if (cmd.load_out)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // The result of the finished operation; failures leave the data fields at their idle values.
    always_comb
    begin
        res_status_next = res_status_reg;
        res_handle_next = res_handle_reg;
        res_object_next = res_object_reg;
        res_flags_next  = res_flags_reg;
        res_fd_next     = res_fd_reg;
        if (cmd.alloc_commit || cmd.set_invalid || cmd.exec)
        begin
            res_status_next = htab_pkg::ST_OK;
            res_handle_next = '0;
            res_object_next = '0;
            res_flags_next  = '0;
            res_fd_next     = htab_pkg::NO_FD;
            if (cmd.alloc_commit)
            begin
                if (full)
                begin
                    res_status_next = htab_pkg::ST_FULL;
                end
                else
                begin
                    res_handle_next = hout_wide[htab_pkg::HOUT_BITS-1:0];
                end
            end
            else if (cmd.set_invalid)
            begin
                res_status_next = htab_pkg::ST_INVALID;
            end
            else
            begin
                case (op_reg)
                    htab_pkg::OP_CLOSE:
                    begin
                        if (protect)
                        begin
                            res_status_next = htab_pkg::ST_INVALID;
                        end
                        else
                        begin
                            res_fd_next = rd_fd;
                        end
                    end
                    htab_pkg::OP_GET:
                    begin
                        if (!rights_ok)
                        begin
                            res_status_next = htab_pkg::ST_DENIED;
                        end
                        else
                        begin
                            res_object_next = rd_obj;
                            res_fd_next     = rd_fd;
                        end
                    end
                    default:
                    begin
                        res_flags_next = rd_acc[26:25];
                        res_fd_next    = new_fd;
                    end
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_item)
        begin
            op_reg     <= in_operation;
            handle_reg <= in_handle;
            obj_reg    <= in_object_id;
            acc_reg    <= in_access_rights;
            inh_reg    <= in_inherit_flag;
            mask_reg   <= in_flag_mask;
            val_reg    <= in_flag_values;
            fdv_reg    <= in_fd_value;
            idx_reg    <= hint_reg;
        end
        if (cmd.scan_step)
        begin
            idx_reg <= idx_reg + (IW+1)'(1);
        end
        res_status_reg <= res_status_next;
        res_handle_reg <= res_handle_next;
        res_object_reg <= res_object_next;
        res_flags_reg  <= res_flags_next;
        res_fd_reg     <= res_fd_next;
        if (cmd.load_out)
        begin
            out_status     <= res_status_reg;
            out_handle     <= res_handle_reg;
            out_object     <= res_object_reg;
            out_prev_flags <= res_flags_reg;
            out_fd         <= res_fd_reg;
        end
    end

    assign out_valid = out_valid_reg;

endmodule

@@ src/handle_table_engine_top.sv @@
// Top level of the handle table engine: stream ports, controller and datapath.
// Get and set_info go from accept through read and execute to the done state, then back to idle.
// Allocate scans from the free hint past used entries, then commits the entry it stops on unless full.
// Close goes through read and execute, and through trim when it removes trailing empty entries, closed one included.
// The result register lets the next beat enter while a result waits to be taken.
// Reset (rst_n, asynchronous, active low) clears all used bits, empties the table at once.
module handle_table_engine_top #(
    parameter int TABLE_ENTRIES = 256,
    parameter int OBJECT_BITS   = 16,
    localparam int IN_W         = 79 + OBJECT_BITS,
    localparam int IN_TDATA_W   = ((IN_W + 7) / 8) * 8,
    localparam int OUT_W        = 30 + OBJECT_BITS,
    localparam int OUT_TDATA_W  = ((OUT_W + 7) / 8) * 8
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   s_tvalid,
    output logic                   s_tready,
    // handle[32], object_id[OBJECT_BITS], access_rights[25], inherit_flag, flag_mask[2],
    // flag_values[2], fd_value[17], zero fill
    input  logic [IN_TDATA_W-1:0]  s_tdata,
    // operation
    input  logic [1:0]             s_tuser,
    output logic                   m_tvalid,
    input  logic                   m_tready,
    // handle_out[11], object_out[OBJECT_BITS], prev_flags[2], fd_out[17], zero fill
    output logic [OUT_TDATA_W-1:0] m_tdata,
    // status
    output logic [1:0]             m_tuser
);

    localparam int OB = OBJECT_BITS;

    htab_pkg::htab_cmd_t cmd;
    htab_pkg::htab_sts_t sts;

    logic [htab_pkg::HOUT_BITS-1:0] out_handle;
    logic [OB-1:0]                  out_object;
    logic [1:0]                     out_prev_flags;
    logic [htab_pkg::FD_BITS-1:0]   out_fd;

    // The controller sequences one beat at a time through scan, read, execute and trim.
    htab_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_tvalid),
        .in_ready (s_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    // The datapath holds the used bits, the entry memory and the result register.
    htab_dp #(
        .TABLE_ENTRIES (TABLE_ENTRIES),
        .OBJECT_BITS   (OBJECT_BITS)
    ) u_dp (
        .clk              (clk),
        .rst_n            (rst_n),
        .cmd              (cmd),
        .sts              (sts),
        .in_operation     (s_tuser),
        .in_handle        (s_tdata[31:0]),
        .in_object_id     (s_tdata[32 +: OB]),
        .in_access_rights (s_tdata[32 + OB +: 25]),
        .in_inherit_flag  (s_tdata[57 + OB]),
        .in_flag_mask     (s_tdata[58 + OB +: 2]),
        .in_flag_values   (s_tdata[60 + OB +: 2]),
        .in_fd_value      (s_tdata[62 + OB +: 17]),
        .out_ready        (m_tready),
        .out_valid        (m_tvalid),
        .out_status       (m_tuser),
        .out_handle       (out_handle),
        .out_object       (out_object),
        .out_prev_flags   (out_prev_flags),
        .out_fd           (out_fd)
    );

    // Pack the result fields from the lowest bit up and fill with zeros.
    assign m_tdata = OUT_TDATA_W'({out_fd, out_prev_flags, out_object, out_handle});

endmodule

@@ src/htab_checker.sv @@
// Port-level assertions for the handle table engine, bound to the top level.
module htab_checker #(
    parameter int OUT_TDATA_W = 48
) (
    input logic                   clk,
    input logic                   rst_n,
    input logic                   s_tvalid,
    input logic                   s_tready,
    input logic                   m_tvalid,
    input logic                   m_tready,
    input logic [OUT_TDATA_W-1:0] m_tdata,
    input logic [1:0]             m_tuser
);

    // A result that is not taken stays offered.
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid)
        else $error("result dropped while stalled");

    // One beat at a time: no beat is taken in the cycle after an accept.
    a_seq: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |=> !s_tready)
        else $error("input taken on consecutive cycles");

    // A failed operation gives no handle and no descriptor.
    a_fail: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser != htab_pkg::ST_OK |-> m_tdata[10:0] == 11'd0 && m_tdata[45:29] == '1)
        else $error("failure result carries data");

    // A handle always has its two low bits clear.
    a_hlow: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> m_tdata[1:0] == 2'b00)
        else $error("handle low bits set");

endmodule

bind handle_table_engine_top htab_checker #(.OUT_TDATA_W(OUT_TDATA_W)) u_htab_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);

@@ dv/handle_table_engine_top_test.sv @@
// Self-checking stream testbench for the handle table engine with a scoreboard and random traffic.
module handle_table_engine_top_test;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int ENTRIES = 256;
    localparam int OBJ_W = 16;
    localparam int IN_W = 79 + OBJ_W;
    localparam int IN_TDATA_W = ((IN_W + 7) / 8) * 8;
    localparam int OUT_W = 30 + OBJ_W;
    localparam int OUT_TDATA_W = ((OUT_W + 7) / 8) * 8;
    localparam int STALL_LIMIT = 20000;
    localparam int RANDOM_ITEMS = 1150;

    // One request as it travels on the input stream.
    typedef struct packed {
        logic [1:0]  op;
        logic [31:0] handle;
        logic [15:0] obj;
        logic [24:0] rights;
        logic        inherit;
        logic [1:0]  mask;
        logic [1:0]  values;
        logic [16:0] fd;
    } request_t;

    // One answer as the table returns it.
    typedef struct packed {
        logic [1:0]  status;
        logic [10:0] handle_out;
        logic [15:0] obj;
        logic [1:0]  prev_flags;
        logic [16:0] fd;
    } answer_t;

    // The scoreboard holds its own copy of the table and a queue of pending answers.
    class handle_scoreboard;
        bit          used [ENTRIES];
        logic [15:0] obj_mem [ENTRIES];
        logic [26:0] acc_mem [ENTRIES];
        logic [16:0] fd_mem [ENTRIES];
        int          last_ix;
        int          hint;
        answer_t     pending [$];
        int          errors;

        function void clear();
            foreach (used[i]) used[i] = 0;
            last_ix = -1;
            hint = 0;
            pending.delete();
            errors = 0;
        endfunction

        function int decode(logic [31:0] h);
            int q;
            q = h >> 2;
            if (q == 0 || q - 1 > last_ix || q - 1 >= ENTRIES) return -1;
            if (!used[q - 1]) return -1;
            return q - 1;
        endfunction

        // Applies a request to the shadow table and queues the answer it implies.
        function void note_request(request_t r);
            answer_t a;
            int i, ix;
            bit found;
            a = '0;
            a.fd = htab_pkg::NO_FD;
            if (r.op == htab_pkg::OP_ALLOC)
            begin
                i = hint;
                found = 0;
                while (i <= last_ix && i < ENTRIES)
                begin
                    if (!used[i])
                    begin
                        found = 1;
                        break;
                    end
                    i++;
                end
                if (!found && i >= ENTRIES) a.status = htab_pkg::ST_FULL;
                else
                begin
                    if (!found) last_ix = i;
                    hint = i + 1;
                    used[i] = 1;
                    obj_mem[i] = r.obj;
                    acc_mem[i] = {1'b0, r.inherit, r.rights};
                    fd_mem[i] = htab_pkg::NO_FD;
                    a.handle_out = 11'((i + 1) << 2);
                end
            end
            else
            begin
                ix = decode(r.handle);
                if (ix < 0) a.status = htab_pkg::ST_INVALID;
                else if (r.op == htab_pkg::OP_CLOSE)
                begin
                    if (acc_mem[ix][26]) a.status = htab_pkg::ST_INVALID;
                    else
                    begin
                        used[ix] = 0;
                        a.fd = fd_mem[ix];
                        fd_mem[ix] = htab_pkg::NO_FD;
                        if (ix < hint) hint = ix;
                        if (ix == last_ix)
                            while (last_ix >= 0 && !used[last_ix]) last_ix--;
                    end
                end
                else if (r.op == htab_pkg::OP_GET)
                begin
                    if ((acc_mem[ix][24:0] & r.rights) != r.rights)
                        a.status = htab_pkg::ST_DENIED;
                    else
                    begin
                        a.obj = obj_mem[ix];
                        a.fd = fd_mem[ix];
                    end
                end
                else
                begin
                    a.prev_flags = acc_mem[ix][26:25];
                    acc_mem[ix][26:25] = (acc_mem[ix][26:25] & ~r.mask) | (r.values & r.mask);
                    if (fd_mem[ix] == htab_pkg::NO_FD) fd_mem[ix] = r.fd;
                    a.fd = fd_mem[ix];
                end
            end
            pending.push_back(a);
        endfunction

        function void check_answer(answer_t got);
            answer_t want;
            if (pending.size() == 0)
            begin
                $error("answer with nothing pending: %h", got);
                errors++;
                return;
            end
            want = pending.pop_front();
            if (got.status !== want.status)
            begin
                $error("status expected %0d actual %0d", want.status, got.status);
                errors++;
            end
            if (got.handle_out !== want.handle_out)
            begin
                $error("handle_out expected %0d actual %0d", want.handle_out, got.handle_out);
                errors++;
            end
            if (got.obj !== want.obj)
            begin
                $error("object_out expected %h actual %h", want.obj, got.obj);
                errors++;
            end
            if (got.prev_flags !== want.prev_flags)
            begin
                $error("prev_flags expected %0d actual %0d", want.prev_flags, got.prev_flags);
                errors++;
            end
            if (got.fd !== want.fd)
            begin
                $error("fd_out expected %h actual %h", want.fd, got.fd);
                errors++;
            end
        endfunction
    endclass

    logic clk = 0;
    logic rst_n = 0;
    logic s_tvalid = 0;
    logic s_tready;
    logic [IN_TDATA_W-1:0] s_tdata = '0;
    logic [1:0] s_tuser = '0;
    logic m_tvalid;
    logic m_tready = 0;
    logic [OUT_TDATA_W-1:0] m_tdata;
    logic [1:0] m_tuser;

    handle_scoreboard board;
    // Idle controls: the sender and receiver each idle at a percentage, zero in the calm stretch.
    int send_idle_pct = 25;
    int recv_idle_pct = 25;
    bit recv_hold = 0;
    int quiet_cycles = 0;
    // Handles recently issued, so random requests mostly hit live entries.
    logic [10:0] live_handles [$];

    always #5 clk = ~clk;

    handle_table_engine_top #(.TABLE_ENTRIES(ENTRIES), .OBJECT_BITS(OBJ_W)) i_dut (
        .clk(clk), .rst_n(rst_n),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser)
    );

    // Sends one request and waits until its beat is accepted; valid stays up for the next one.
    task automatic send_request(request_t r);
        while ($urandom_range(99) < send_idle_pct)
        begin
            s_tvalid <= 0;
            @(posedge clk);
        end
        s_tvalid <= 1;
        s_tuser <= r.op;
        s_tdata <= IN_TDATA_W'({r.fd, r.values, r.mask, r.inherit, r.rights, r.obj, r.handle});
        @(posedge clk);
        while (!s_tready) @(posedge clk);
        board.note_request(r);
    endtask

    function automatic request_t build(logic [1:0] op, logic [31:0] h);
        request_t r;
        r.op = op;
        r.handle = h;
        r.obj = 16'($urandom);
        r.rights = 25'($urandom);
        r.inherit = 1'($urandom);
        r.mask = 2'($urandom);
        r.values = 2'($urandom);
        r.fd = ($urandom_range(3) == 0) ? htab_pkg::NO_FD : 17'($urandom);
        return r;
    endfunction

    // Picks a handle: usually a live one, sometimes a stale or arbitrary value.
    function automatic logic [31:0] pick_handle();
        int k;
        if (live_handles.size() > 0 && $urandom_range(9) < 8)
        begin
            k = $urandom_range(live_handles.size() - 1);
            return {21'($urandom_range(1) ? 0 : $urandom), live_handles[k]} |
                   32'($urandom_range(3));
        end
        return $urandom_range(1) ? $urandom : 32'($urandom_range(1100));
    endfunction

    // Stops offering beats and waits until every expected answer has come back.
    task automatic drain();
        s_tvalid <= 0;
        while (board.pending.size() != 0) @(posedge clk);
    endtask

    // Receiver: takes answers with random stalls; a hold stops it entirely.
    always @(posedge clk)
    begin
        if (m_tvalid && m_tready)
            board.check_answer(answer_t'({m_tuser, m_tdata[10:0], m_tdata[26:11],
                                          m_tdata[28:27], m_tdata[OUT_W-1:29]}));
        m_tready <= !recv_hold && ($urandom_range(99) >= recv_idle_pct);
    end

    // Watchdog: any cycle without an accepted beat counts toward the limit.
    always @(posedge clk)
    begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) quiet_cycles <= 0;
        else quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= STALL_LIMIT)
        begin
            $display("** handle_table_engine_top: FAILED **");
            $finish;
        end
    end

    initial
    begin
        request_t r;
        int n, w;
        board = new();
        board.clear();
        repeat (7) @(posedge clk);
        rst_n <= 1;
        @(posedge clk);

        // Directed part: operations on an empty table, extremes, protect and deny.
        send_request(build(htab_pkg::OP_GET, 32'd4));
        send_request(build(htab_pkg::OP_CLOSE, 32'd0));
        send_request(build(htab_pkg::OP_SET, 32'hFFFF_FFFF));
        r = build(htab_pkg::OP_ALLOC, 0);
        r.obj = 16'hFFFF;
        r.rights = '1;
        r.inherit = 1;
        send_request(r);
        r = build(htab_pkg::OP_ALLOC, 0);
        r.obj = 0;
        r.rights = 0;
        r.inherit = 0;
        send_request(r);
        r = build(htab_pkg::OP_GET, 32'd7);
        r.rights = '1;
        send_request(r);
        r = build(htab_pkg::OP_GET, 32'd8);
        r.rights = 25'h1;
        send_request(r);
        r = build(htab_pkg::OP_SET, 32'd4);
        r.mask = 2'b11;
        r.values = 2'b10;
        r.fd = 17'h0FFFF;
        send_request(r);
        send_request(build(htab_pkg::OP_CLOSE, 32'd4));
        r = build(htab_pkg::OP_SET, 32'd5);
        r.mask = 2'b10;
        r.values = 2'b00;
        send_request(r);
        send_request(build(htab_pkg::OP_GET, 32'd4));
        send_request(build(htab_pkg::OP_CLOSE, 32'd4));
        send_request(build(htab_pkg::OP_CLOSE, 32'd8));
        send_request(build(htab_pkg::OP_CLOSE, 32'd12));
        send_request(build(htab_pkg::OP_GET, 32'h0000_0404));
        drain();

        // Fill the table to capacity and ask once more for a full answer.
        send_idle_pct = 0;
        recv_idle_pct = 0;
        for (n = 0; n < ENTRIES + 1; n++) send_request(build(htab_pkg::OP_ALLOC, 0));
        for (n = 1; n <= ENTRIES; n++) live_handles.push_back(11'(n << 2));
        drain();

        // Back pressure: the receiver holds off while the sender keeps offering beats.
        send_idle_pct = 25;
        recv_idle_pct = 25;
        fork
            begin
                recv_hold = 1;
                repeat (300) @(posedge clk);
                recv_hold = 0;
            end
            begin
                for (w = 0; w < 20; w++)
                    send_request(build(htab_pkg::OP_GET, pick_handle()));
                drain();
            end
        join

        // Random part: mostly operations on live handles; frees keep the table churning.
        for (n = 0; n < RANDOM_ITEMS; n++)
        begin
            if (n == 400)
            begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            if (n == 650)
            begin
                send_idle_pct = 25;
                recv_idle_pct = 25;
            end
            if (n == 900) drain();
            case ($urandom_range(9)) inside
                [0:2]: r = build(htab_pkg::OP_ALLOC, 0);
                [3:5]: r = build(htab_pkg::OP_CLOSE, pick_handle());
                [6:7]: r = build(htab_pkg::OP_GET, pick_handle());
                default: r = build(htab_pkg::OP_SET, pick_handle());
            endcase
            if (r.op == htab_pkg::OP_SET && $urandom_range(3) != 0) r.values[1] = 0;
            if (r.op == htab_pkg::OP_GET && $urandom_range(1)) r.rights = 25'($urandom_range(7));
            send_request(r);
            if (r.op == htab_pkg::OP_ALLOC && board.pending[$].status == htab_pkg::ST_OK)
                live_handles.push_back(board.pending[$].handle_out);
            if (live_handles.size() > 64) void'(live_handles.pop_front());
        end

        drain();
        repeat (300) @(posedge clk);
        if (board.errors == 0 && board.pending.size() == 0)
            $display("** handle_table_engine_top: PASSED **");
        else
            $display("** handle_table_engine_top: FAILED **");
        $finish;
    end
endmodule

@@ sim.f @@
src/htab_pkg.sv
src/htab_ctrl.sv
src/htab_dp.sv
src/handle_table_engine_top.sv
src/htab_checker.sv
dv/handle_table_engine_top_test.sv
